// File: design/wsag_pkg.sv
// Shared constants, codes and types for the windowed speed gear shifter.
`default_nettype none

package wsag_pkg;

    // Ring depth per wheel side
    localparam int SAMPLES = 8;
    localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    // Field widths
    localparam int OP_W = 3;
    localparam int SPEED_W = 16;
    localparam int DELTA_W = SPEED_W + 1;
    localparam int THR_W = 15;
    localparam int COUNT_W = 8;
    localparam int CFG_W = 15;
    localparam int CFG_IDX_W = 2;

    // Running sum of both rings, with margin
    localparam int SUM_W = 18 + SLOT_W;

    // Thresholds are scaled by both window lengths instead of dividing the sum
    localparam int LIM_SCALE = 2 * SAMPLES;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLES - 1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_STORE = 3'd0;
    localparam logic [OP_W-1:0] OP_EVAL = 3'd1;
    localparam logic [OP_W-1:0] OP_FORCE_HIGH = 3'd2;
    localparam logic [OP_W-1:0] OP_FORCE_LOW = 3'd3;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 2'd3;

    // Configuration register reset values
    localparam logic RST_AUTO_ENABLE = 1'b1;
    localparam logic [THR_W-1:0] RST_HIGH_THR = 15'd3000;
    localparam logic [THR_W-1:0] RST_LOW_THR = 15'd2000;
    localparam logic [COUNT_W-1:0] RST_PERSIST = 8'd3;

    typedef struct packed {
        logic auto_enable;
        logic [THR_W-1:0] high_thr;
        logic [THR_W-1:0] low_thr;
        logic [COUNT_W-1:0] persist;
    } cfg_t;

endpackage

`default_nettype wire

// File: design/wsag_lane.sv
// One wheel side: sample ring and the change that a new sample makes to the sum.
`default_nettype none

module wsag_lane (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               store_en,
    input  wire logic [wsag_pkg::SLOT_W-1:0]        slot,
    input  wire logic signed [wsag_pkg::SPEED_W-1:0] sample,
    output logic signed [wsag_pkg::DELTA_W-1:0]     delta
);
    import wsag_pkg::*;

    logic signed [SPEED_W-1:0] ring_reg [SAMPLES];
    logic signed [SPEED_W-1:0] old_sample;

    // Read the entry about to be replaced
    assign old_sample = ring_reg[slot];

    // New sample minus the one it overwrites
    assign delta = DELTA_W'(sample) - DELTA_W'(old_sample);

    // Write the ring on a store transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SAMPLES; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (store_en)
        begin
            ring_reg[slot] <= sample;
        end
    end

endmodule

`default_nettype wire

// File: design/wsag_merge.sv
// Merge stage: running sum, write slot, hysteresis counters and gear state.
`default_nettype none

module wsag_merge (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_en,
    input  wire logic [wsag_pkg::OP_W-1:0]           operation,
    input  wire wsag_pkg::cfg_t                      cfg,
    input  wire logic signed [wsag_pkg::DELTA_W-1:0] delta_left,
    input  wire logic signed [wsag_pkg::DELTA_W-1:0] delta_right,
    output logic                                     store_en,
    output logic [wsag_pkg::SLOT_W-1:0]              slot,
    output logic                                     gear_next
);
    import wsag_pkg::*;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic signed [SUM_W-1:0] window_sum_reg, window_sum_next;
    logic [COUNT_W-1:0] up_count_reg, up_count_next;
    logic [COUNT_W-1:0] down_count_reg, down_count_next;
    logic gear_reg;

    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] hi_lim;
    logic [SUM_W-1:0] lo_lim;
    logic [COUNT_W-1:0] up_inc;
    logic [COUNT_W-1:0] down_inc;

    assign slot = slot_reg;
    assign store_en = item_en && (operation == OP_STORE);

    // Magnitude of the combined window sum and the scaled limits
    assign mag = window_sum_reg[SUM_W-1] ? SUM_W'(-window_sum_reg) : SUM_W'(window_sum_reg);
    assign hi_lim = SUM_W'(cfg.high_thr) * SUM_W'(LIM_SCALE);
    assign lo_lim = SUM_W'(cfg.low_thr) * SUM_W'(LIM_SCALE);

    // Saturating increments
    assign up_inc = (up_count_reg == COUNT_MAX) ? COUNT_MAX : up_count_reg + 1'b1;
    assign down_inc = (down_count_reg == COUNT_MAX) ? COUNT_MAX : down_count_reg + 1'b1;

    // Decode the operation of the accepted transaction
    always_comb
    begin
        slot_next = slot_reg;
        window_sum_next = window_sum_reg;
        up_count_next = up_count_reg;
        down_count_next = down_count_reg;
        gear_next = gear_reg;
        if (item_en)
        begin
            case (operation)
                OP_STORE:
                begin
                    window_sum_next = window_sum_reg + SUM_W'(delta_left)
                                    + SUM_W'(delta_right);
                    slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                end
                OP_EVAL:
                begin
                    if (cfg.auto_enable)
                    begin
                        // High test first so crossed thresholds favor high gear
                        if (mag > hi_lim)
                        begin
                            up_count_next = up_inc;
                            down_count_next = '0;
                            if (up_inc > cfg.persist)
                            begin
                                gear_next = 1'b1;
                            end
                        end
                        else if (mag < lo_lim)
                        begin
                            down_count_next = down_inc;
                            up_count_next = '0;
                            if (down_inc > cfg.persist)
                            begin
                                gear_next = 1'b0;
                            end
                        end
                        else
                        begin
                            up_count_next = '0;
                            down_count_next = '0;
                        end
                    end
                end
                OP_FORCE_HIGH:
                begin
                    gear_next = 1'b1;
                end
                OP_FORCE_LOW:
                begin
                    gear_next = 1'b0;
                end
                OP_TOGGLE:
                begin
                    gear_next = !gear_reg;
                end
                default:
                begin
                    gear_next = gear_reg;
                end
            endcase
        end
    end

    // Hold the merged state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            window_sum_reg <= '0;
            up_count_reg <= '0;
            down_count_reg <= '0;
            gear_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            window_sum_reg <= window_sum_next;
            up_count_reg <= up_count_next;
            down_count_reg <= down_count_next;
            gear_reg <= gear_next;
        end
    end

    // The two counters are never both running
    a_counters_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((up_count_reg != '0) && (down_count_reg != '0)))
        else $error("up and down counters both nonzero");

    // No transaction, no change to sum or gear
    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !item_en |=> ($stable(window_sum_reg) && $stable(gear_reg) && $stable(slot_reg)))
        else $error("state changed without a transaction");

    // Only a store moves the write slot
    a_slot_on_store: assert property (@(posedge clk) disable iff (!rst_n)
        (item_en && !store_en) |=> $stable(slot_reg))
        else $error("write slot moved on a non-store transaction");

endmodule

`default_nettype wire

// File: design/windowed_speed_auto_gear_shift.sv
// Top level: configuration registers, two wheel lanes, merge stage and output skid stage.
`default_nettype none

// Windowed speed automatic gear shift. Accepts one transaction per clock while
// in_stall is low and returns one result per transaction, registered on
// acceptance, through a two-entry output stage (result register plus skid
// register); in_stall only rises when both entries are full. Each transaction's
// full update (ring write, running sum update, hysteresis compare, gear
// update) is one combinational pass, its depth set by the ring read and
// delta subtract feeding the sum add on a store, or by the magnitude compare
// feeding the counter and gear update on an evaluation. Reset clears both
// sample rings, the sum, the counters and the gear at once; no clearing pass.
// Write configuration only while no transaction is in flight.
module windowed_speed_auto_gear_shift (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [wsag_pkg::OP_W-1:0]            operation,
    input  wire logic signed [wsag_pkg::SPEED_W-1:0]  left_speed,
    input  wire logic signed [wsag_pkg::SPEED_W-1:0]  right_speed,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      high_gear,
    output logic                                      turning,
    input  wire logic                                 cfg_write_en,
    input  wire logic [wsag_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [wsag_pkg::CFG_W-1:0]           cfg_data
);
    import wsag_pkg::*;

    cfg_t cfg_reg;
    logic item_en;
    logic store_en;
    logic [SLOT_W-1:0] slot;
    logic signed [DELTA_W-1:0] delta_left;
    logic signed [DELTA_W-1:0] delta_right;
    logic gear_next;
    logic turning_now;

    logic out_valid_reg;
    logic out_gear_reg;
    logic out_turning_reg;
    logic skid_valid_reg;
    logic skid_gear_reg;
    logic skid_turning_reg;
    logic out_take;

    assign in_stall = skid_valid_reg;
    assign item_en = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    assign out_valid = out_valid_reg;
    assign high_gear = out_gear_reg;
    assign turning = out_turning_reg;

    // Opposite signs, zero never counts
    assign turning_now = (left_speed[SPEED_W-1] && !right_speed[SPEED_W-1] && (right_speed != '0))
                      || (right_speed[SPEED_W-1] && !left_speed[SPEED_W-1] && (left_speed != '0));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_enable <= RST_AUTO_ENABLE;
            cfg_reg.high_thr <= RST_HIGH_THR;
            cfg_reg.low_thr <= RST_LOW_THR;
            cfg_reg.persist <= RST_PERSIST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_AUTO_ENABLE: cfg_reg.auto_enable <= cfg_data[0];
                CFG_HIGH_THR:    cfg_reg.high_thr <= cfg_data[THR_W-1:0];
                CFG_LOW_THR:     cfg_reg.low_thr <= cfg_data[THR_W-1:0];
                CFG_PERSIST:     cfg_reg.persist <= cfg_data[COUNT_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Left and right lanes
    wsag_lane u_lane_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .store_en (store_en),
        .slot     (slot),
        .sample   (left_speed),
        .delta    (delta_left)
    );

    wsag_lane u_lane_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .store_en (store_en),
        .slot     (slot),
        .sample   (right_speed),
        .delta    (delta_right)
    );

    // Combine lane deltas and run the shift decision
    wsag_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_en     (item_en),
        .operation   (operation),
        .cfg         (cfg_reg),
        .delta_left  (delta_left),
        .delta_right (delta_right),
        .store_en    (store_en),
        .slot        (slot),
        .gear_next   (gear_next)
    );

    // Output register and skid stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (item_en)
            begin
                if (out_valid_reg && out_stall)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_gear_reg <= skid_gear_reg;
                out_turning_reg <= skid_turning_reg;
            end
        end
        else if (item_en)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_gear_reg <= gear_next;
                skid_turning_reg <= turning_now;
            end
            else
            begin
                out_gear_reg <= gear_next;
                out_turning_reg <= turning_now;
            end
        end
    end

    // A filled skid entry always sits behind a valid result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

endmodule

`default_nettype wire
